>>> src/bpa_pkg.sv
package bpa_pkg;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOT_USED = 2'd3;

  // free map word layout
  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = 5;

  localparam int CFG_W = 11;

  typedef struct packed {
    logic       command;
    logic [3:0] block_order;
    logic [9:0] page_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  granted_page;
    logic [10:0] free_total;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN_NEXT,
    OP_TAKE,
    OP_SPLIT_DN,
    OP_SET_ADD,
    OP_RELEASE,
    OP_BUDDY,
    OP_MERGE_UP,
    OP_AT_PAGE,
    OP_SET,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic ord_bad;
    logic out_range;
    logic hit;
    logic scan_last;
    logic in_use;
    logic split_more;
    logic merge_more;
    logic tgt_ok;
    logic bit_set;
  } dp_stat_t;

endpackage

>>> src/bpa_if.sv
interface bpa_req_if;
  logic          valid;
  logic          ready;
  bpa_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpa_rsp_if;
  logic          valid;
  logic          ready;
  bpa_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bpa_pkg::CFG_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bpa_ctrl.sv
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpa_pkg::dp_cmd_t  cmd_o,
  input  bpa_pkg::dp_stat_t stat_i
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECIDE,
    S_SCAN_RD, S_SCAN_CHK,
    S_SPLIT, S_SPLIT_RD, S_SPLIT_WR,
    S_FREE_RD, S_FREE_CHK,
    S_MERGE, S_MERGE_RD, S_MERGE_CHK,
    S_PUT, S_PUT_RD, S_PUT_WR,
    S_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] status_q, status_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op     = bpa_pkg::OP_NONE;
    cmd_o.status = status_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = bpa_pkg::OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = bpa_pkg::OP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.is_free) begin
          if (stat_i.out_range) begin
            status_d = bpa_pkg::ST_RANGE;
            state_d  = S_FINISH;
          end else begin
            state_d = S_FREE_RD;
          end
        end else if (stat_i.ord_bad) begin
          status_d = bpa_pkg::ST_NO_FREE;
          state_d  = S_FINISH;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (stat_i.hit) begin
          cmd_o.op = bpa_pkg::OP_TAKE;
          state_d  = S_SPLIT;
        end else if (stat_i.scan_last) begin
          status_d = bpa_pkg::ST_NO_FREE;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = bpa_pkg::OP_SCAN_NEXT;
          state_d  = S_SCAN_RD;
        end
      end
      S_SPLIT: begin
        if (stat_i.split_more) begin
          cmd_o.op = bpa_pkg::OP_SPLIT_DN;
          state_d  = S_SPLIT_RD;
        end else begin
          status_d = bpa_pkg::ST_DONE;
          state_d  = S_FINISH;
        end
      end
      S_SPLIT_RD: state_d = stat_i.tgt_ok ? S_SPLIT_WR : S_SPLIT;
      S_SPLIT_WR: begin
        cmd_o.op = bpa_pkg::OP_SET_ADD;
        state_d  = S_SPLIT;
      end
      S_FREE_RD: state_d = S_FREE_CHK;
      S_FREE_CHK: begin
        if (!stat_i.in_use) begin
          status_d = bpa_pkg::ST_NOT_USED;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = bpa_pkg::OP_RELEASE;
          state_d  = S_MERGE;
        end
      end
      S_MERGE: begin
        if (stat_i.merge_more) begin
          cmd_o.op = bpa_pkg::OP_BUDDY;
          state_d  = S_MERGE_RD;
        end else begin
          state_d = S_PUT;
        end
      end
      S_MERGE_RD: state_d = stat_i.tgt_ok ? S_MERGE_CHK : S_PUT;
      S_MERGE_CHK: begin
        if (stat_i.bit_set) begin
          cmd_o.op = bpa_pkg::OP_MERGE_UP;
          state_d  = S_MERGE;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.op = bpa_pkg::OP_AT_PAGE;
        state_d  = S_PUT_RD;
      end
      S_PUT_RD: state_d = S_PUT_WR;
      S_PUT_WR: begin
        cmd_o.op = bpa_pkg::OP_SET;
        status_d = bpa_pkg::ST_DONE;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = bpa_pkg::OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      status_q    <= bpa_pkg::ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/bpa_datapath.sv
module bpa_datapath #(
  parameter int NUM_PAGES   = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpa_pkg::dp_cmd_t          cmd_i,
  output bpa_pkg::dp_stat_t         stat_o,
  input  bpa_pkg::req_t             req_i,
  input  logic                      cfg_we_i,
  input  logic [bpa_pkg::CFG_W-1:0] cfg_data_i,
  output bpa_pkg::rsp_t             rsp_o
);

  localparam int WB  = bpa_pkg::WORD_BITS;
  localparam int WSH = bpa_pkg::WORD_SH;

  function automatic int blocks_at(int o);
    return ((NUM_PAGES - 1) >> o) + 1;
  endfunction

  function automatic int word_base(int o);
    int s;
    s = 0;
    for (int k = 0; k < o; k++) begin
      s += (blocks_at(k) + WB - 1) >> WSH;
    end
    return s;
  endfunction

  localparam int PGW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int PW  = ((PGW > ORDER_COUNT) ? PGW : ORDER_COUNT) + 2;
  localparam int OW  = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam int MW  = word_base(ORDER_COUNT);
  localparam int MAW = (MW > 1) ? $clog2(MW) : 1;
  localparam int CL  = (MW > NUM_PAGES) ? MW : NUM_PAGES;
  localparam int CW  = $clog2(CL);
  localparam int SW  = ORDER_COUNT + 12;

  logic [PW-1:0]  blk_a  [ORDER_COUNT];
  logic [MAW-1:0] base_a [ORDER_COUNT];

  for (genvar g = 0; g < ORDER_COUNT; g++) begin : g_tab
    assign blk_a[g]  = PW'(blocks_at(g));
    assign base_a[g] = MAW'(word_base(g));
  end

  logic                     cmd_q, cmd_d;
  logic [3:0]               req_ord_q, req_ord_d;
  logic [OW-1:0]            ord_q, ord_d;
  logic [PW-1:0]            page_q, page_d;
  logic [PW-1:0]            tgt_q, tgt_d;
  logic                     tok_q, tok_d;
  logic                     range_q, range_d;
  logic [CW-1:0]            clr_q, clr_d;
  logic [10:0]              total_q, total_d;
  logic [bpa_pkg::CFG_W-1:0] usable_q;
  bpa_pkg::rsp_t            rsp_q, rsp_d;

  logic [WB-1:0]  map_rd, map_wd;
  logic           map_we;
  logic [MAW-1:0] map_addr, tgt_addr;
  logic [0:0]     use_rd, use_wd;
  logic           use_we;
  logic [PGW-1:0] use_addr;

  logic [PW-1:0]  blk, hit_page, half, buddy, one_o;
  logic [WSH-1:0] bitsel, lsb;
  logic           last_word;
  logic [OW-1:0]  ord_sat, ord_dn;
  logic [SW-1:0]  amt, sum_add;
  logic [10:0]    tot_add, tot_sub;
  logic [PW-1:0]  idx_ext;

  always_comb begin
    blk      = tgt_q >> ord_q;
    bitsel   = blk[WSH-1:0];
    tgt_addr = base_a[ord_q] + MAW'(blk >> WSH);
    last_word = ((((blk >> WSH) + PW'(1)) << WSH) >= blk_a[ord_q]);
    lsb = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (map_rd[i]) lsb = WSH'(i);
    end
    hit_page = ((blk & ~PW'(WB - 1)) | PW'(lsb)) << ord_q;
    one_o    = PW'(1) << ord_q;
    ord_dn   = ord_q - OW'(1);
    half     = page_q + (PW'(1) << ord_dn);
    buddy    = page_q ^ one_o;
    amt      = SW'(1) << ord_q;
    sum_add  = SW'(total_q) + amt;
    tot_add  = (sum_add > SW'(2047)) ? 11'd2047 : sum_add[10:0];
    tot_sub  = (amt > SW'(total_q)) ? 11'd0 : 11'(SW'(total_q) - amt);
    ord_sat  = (int'(req_i.block_order) > ORDER_COUNT - 1) ? OW'(ORDER_COUNT - 1)
                                                           : OW'(req_i.block_order);
    idx_ext  = PW'(req_i.page_index);
  end

  always_comb begin
    cmd_d     = cmd_q;
    req_ord_d = req_ord_q;
    ord_d     = ord_q;
    page_d    = page_q;
    tgt_d     = tgt_q;
    tok_d     = tok_q;
    range_d   = range_q;
    clr_d     = clr_q;
    total_d   = total_q;
    rsp_d     = rsp_q;
    map_we    = 1'b0;
    map_wd    = map_rd;
    map_addr  = tgt_addr;
    use_we    = 1'b0;
    use_wd    = 1'b0;
    use_addr  = page_q[PGW-1:0];
    case (cmd_i.op)
      bpa_pkg::OP_CLEAR: begin
        map_addr = clr_q[MAW-1:0];
        use_addr = clr_q[PGW-1:0];
        map_we   = int'(clr_q) < MW;
        map_wd   = '0;
        use_we   = int'(clr_q) < NUM_PAGES;
        use_wd   = 1'b1;
        clr_d    = clr_q + CW'(1);
      end
      bpa_pkg::OP_LOAD: begin
        cmd_d     = req_i.command;
        req_ord_d = req_i.block_order;
        tgt_d     = '0;
        range_d   = (int'(req_i.page_index) >= int'(usable_q)) ||
                    (int'(req_i.page_index) >= NUM_PAGES);
        if (req_i.command == bpa_pkg::CMD_FREE) begin
          ord_d  = ord_sat;
          page_d = idx_ext & ~((PW'(1) << ord_sat) - PW'(1));
        end else begin
          ord_d = (int'(req_i.block_order) < ORDER_COUNT) ? OW'(req_i.block_order)
                                                          : '0;
        end
      end
      bpa_pkg::OP_SCAN_NEXT: begin
        if (last_word) begin
          ord_d = ord_q + OW'(1);
          tgt_d = '0;
        end else begin
          tgt_d = (((blk >> WSH) + PW'(1)) << WSH) << ord_q;
        end
      end
      bpa_pkg::OP_TAKE: begin
        map_we   = 1'b1;
        map_wd   = map_rd & ~(WB'(1) << lsb);
        page_d   = hit_page;
        use_addr = hit_page[PGW-1:0];
        use_we   = 1'b1;
        use_wd   = 1'b1;
        total_d  = tot_sub;
      end
      bpa_pkg::OP_SPLIT_DN: begin
        ord_d = ord_dn;
        tgt_d = half;
        tok_d = int'(half) < NUM_PAGES;
      end
      bpa_pkg::OP_SET_ADD: begin
        map_we  = 1'b1;
        map_wd  = map_rd | (WB'(1) << bitsel);
        total_d = tot_add;
      end
      bpa_pkg::OP_RELEASE: begin
        use_we  = 1'b1;
        use_wd  = 1'b0;
        total_d = tot_add;
      end
      bpa_pkg::OP_BUDDY: begin
        tgt_d = buddy;
        tok_d = int'(buddy) < NUM_PAGES;
      end
      bpa_pkg::OP_MERGE_UP: begin
        map_we = 1'b1;
        map_wd = map_rd & ~(WB'(1) << bitsel);
        page_d = page_q & tgt_q;
        ord_d  = ord_q + OW'(1);
      end
      bpa_pkg::OP_AT_PAGE: tgt_d = page_q;
      bpa_pkg::OP_SET: begin
        map_we = 1'b1;
        map_wd = map_rd | (WB'(1) << bitsel);
      end
      bpa_pkg::OP_RESULT: begin
        rsp_d.status       = cmd_i.status;
        rsp_d.granted_page = (cmd_i.status == bpa_pkg::ST_DONE &&
                              cmd_q == bpa_pkg::CMD_ALLOC) ? 10'(page_q) : 10'd0;
        rsp_d.free_total   = total_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      total_q  <= '0;
      usable_q <= bpa_pkg::CFG_W'(1024);
    end else begin
      clr_q   <= clr_d;
      total_q <= total_d;
      if (cfg_we_i) usable_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    req_ord_q <= req_ord_d;
    ord_q     <= ord_d;
    page_q    <= page_d;
    tgt_q     <= tgt_d;
    tok_q     <= tok_d;
    range_q   <= range_d;
    rsp_q     <= rsp_d;
  end

  bpa_ram #(.WIDTH(WB), .DEPTH(MW)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (map_wd),
    .rdata_o (map_rd)
  );

  bpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_use_ram (
    .clk_i   (clk_i),
    .we_i    (use_we),
    .addr_i  (use_addr),
    .wdata_i (use_wd),
    .rdata_o (use_rd)
  );

  always_comb begin
    stat_o.clr_last   = (clr_q == CW'(CL - 1));
    stat_o.is_free    = (cmd_q == bpa_pkg::CMD_FREE);
    stat_o.ord_bad    = int'(req_ord_q) >= ORDER_COUNT;
    stat_o.out_range  = range_q;
    stat_o.hit        = |map_rd;
    stat_o.scan_last  = (ord_q == OW'(ORDER_COUNT - 1)) && last_word;
    stat_o.in_use     = use_rd[0];
    stat_o.split_more = int'(ord_q) > int'(req_ord_q);
    stat_o.merge_more = int'(ord_q) < ORDER_COUNT - 1;
    stat_o.tgt_ok     = tok_q;
    stat_o.bit_set    = map_rd[bitsel];
  end

  assign rsp_o = rsp_q;

endmodule

>>> src/buddy_page_allocator_core.sv
// buddy page allocator
// req_i carries one item per request: command (allocate or free), block_order
// and page_index. rsp_o returns exactly one item per request with status,
// granted_page and free_total. cfg_i writes usable_pages; the user must write
// it only while the block is idle, which the block itself does not enforce.
// an allocate is accepted and decoded, then scans the free map word by word
// (32 blocks a word) from the requested order upward, then splits the found
// block one level at a time down to the requested order and leaves the split
// loop. a free is accepted, checked and the page released, then merges with
// each free buddy in turn and records the final free block. then the result
// is registered. with 1024 pages and 11 orders the worst case is an order 0
// allocate served from the top order: 68 words scanned and 10 splits, paced
// by the single-port free map memory and its read-modify-write.
// the block works on one item at a time; the next item is accepted as soon as
// the previous one has its result registered, even while that result waits.
// after reset a clearing pass over max(map words, NUM_PAGES) entries (1024 by
// default) empties the free map and marks every page in use; no item is
// accepted meanwhile. a stalled receiver holds the result in the output
// register and the block stalls before loading the next result.
module buddy_page_allocator_core #(
  parameter int NUM_PAGES   = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o,
  bpa_cfg_if.sink   cfg_i
);

  // command and status between sequencer and datapath
  bpa_pkg::dp_cmd_t  dp_cmd;
  bpa_pkg::dp_stat_t dp_stat;

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  bpa_datapath #(
    .NUM_PAGES   (NUM_PAGES),
    .ORDER_COUNT (ORDER_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .req_i      (req_i.data),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .rsp_o      (rsp_o.data)
  );

endmodule
